// File: hw/rtl/hmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmt_pkg
// Shared types and constants of the heartbeat membership table.
// ----------------------------------------------------------------------------
package hmt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int MAX_RESULTS = 32;
  localparam int OCC_W       = 6;
  localparam int CFG_IDX_W   = 2;

  localparam logic [15:0] TFAIL   = 16'd5;
  localparam logic [15:0] TREMOVE = 16'd20;

  // result status codes
  localparam logic [2:0] STAT_UNCHANGED = 3'd0;
  localparam logic [2:0] STAT_UPDATED   = 3'd1;
  localparam logic [2:0] STAT_INSERTED  = 3'd2;
  localparam logic [2:0] STAT_FULL      = 3'd3;
  localparam logic [2:0] STAT_GOSSIP    = 3'd4;
  localparam logic [2:0] STAT_EMPTY     = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAIL_TIMEOUT   = 2'd0,
    CFG_REMOVE_TIMEOUT = 2'd1,
    CFG_SELF_ID        = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_MERGE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MSCAN,
    S_MDONE,
    S_TSWEEP,
    S_TEMIT,
    S_TEND,
    S_TEMPTY
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] now;
    logic [31:0] member_id;
    logic [15:0] member_port;
    logic [31:0] member_beat;
  } item_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] beat;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic [15:0] fail_timeout;
    logic [15:0] remove_timeout;
    logic [31:0] self_id;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [31:0]      id;
    logic [15:0]      port;
    logic [31:0]      beat;
    logic             last;
    logic [OCC_W-1:0] occupancy;
  } res_t;

endpackage

// File: hw/rtl/hmt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmt_if
// Channel interfaces: input items, result items and register writes.
// ----------------------------------------------------------------------------
interface hmt_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] now;
  logic [31:0] member_id;
  logic [15:0] member_port;
  logic [31:0] member_beat;
  modport source (output valid, cmd, now, member_id, member_port, member_beat, input ready);
  modport sink   (input valid, cmd, now, member_id, member_port, member_beat, output ready);
endinterface

interface hmt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] out_id;
  logic [15:0] out_port;
  logic [31:0] out_beat;
  logic        last;
  logic [5:0]  occupancy;
  modport source (output valid, status, out_id, out_port, out_beat, last, occupancy,
                  input ready);
  modport sink   (input valid, status, out_id, out_port, out_beat, last, occupancy,
                  output ready);
endinterface

interface hmt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/heartbeat_membership_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_membership_table_core
// Gossip membership table: merges offered entries, ages and emits on ticks.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  in_bus   | in        | cmd, now, member_id, member_port, member_beat
//  out_bus  | out       | status, out_id, out_port, out_beat, last, occupancy
//  cfg_bus  | in        | index, data (always ready)
//
// a merge holds the back end for dispatch, a scan at one slot a cycle while no result
// is held back on out_bus, the registered read and drain, then the result
// a tick makes two scans (sweep, then emission); a tick on an empty table makes none;
// a result that out_bus.ready holds back stalls the scan or the final step
// the slot memory has a single read port, so each scan reads one slot at a time
// reset clears valid bits, counts and own heartbeat at once; no clearing pass
// a two-entry queue takes items while the back end works; results stall in place
module heartbeat_membership_table_core #(
  parameter int TABLE_DEPTH = hmt_pkg::TABLE_DEPTH
) (
  input logic     clk,
  input logic     rst_n,
  hmt_in_if.sink  in_bus,
  hmt_out_if.source out_bus,
  hmt_cfg_if.sink cfg_bus
);

  hmt_pkg::cfg_t  cfg_r, cfg_nxt;
  logic           q_valid;
  hmt_pkg::item_t q_item;
  logic           q_pop;
  logic           res_valid;
  hmt_pkg::res_t  res_data;

  assign cfg_bus.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_bus.valid) begin
      unique case (hmt_pkg::cfg_idx_t'(cfg_bus.index))
        hmt_pkg::CFG_FAIL_TIMEOUT:   cfg_nxt.fail_timeout   = cfg_bus.data[15:0];
        hmt_pkg::CFG_REMOVE_TIMEOUT: cfg_nxt.remove_timeout = cfg_bus.data[15:0];
        hmt_pkg::CFG_SELF_ID:        cfg_nxt.self_id        = cfg_bus.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fail_timeout   <= hmt_pkg::TFAIL;
      cfg_r.remove_timeout <= hmt_pkg::TREMOVE;
      cfg_r.self_id        <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hmt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  hmt_back #(
    .DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (out_bus.ready)
  );

  assign out_bus.valid     = res_valid;
  assign out_bus.status    = res_data.status;
  assign out_bus.out_id    = res_data.id;
  assign out_bus.out_port  = res_data.port;
  assign out_bus.out_beat  = res_data.beat;
  assign out_bus.last      = res_data.last;
  assign out_bus.occupancy = res_data.occupancy;

  // a full table reports every slot taken
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.status == hmt_pkg::STAT_FULL
      |-> out_bus.occupancy == hmt_pkg::OCC_W'(TABLE_DEPTH))
    else $error("table full reported below depth");

  a_insert_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.status == hmt_pkg::STAT_INSERTED |-> out_bus.occupancy != '0)
    else $error("insert with empty occupancy");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.status == hmt_pkg::STAT_EMPTY
      |-> out_bus.out_id == '0 && out_bus.out_beat == '0 && out_bus.last)
    else $error("empty result carries an entry");

  // only gossip runs have results that are not the final one
  a_last_gossip: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.last |-> out_bus.status == hmt_pkg::STAT_GOSSIP)
    else $error("non-final result outside a gossip run");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> out_bus.occupancy <= hmt_pkg::OCC_W'(TABLE_DEPTH))
    else $error("occupancy beyond table depth");

endmodule

// File: hw/rtl/hmt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmt_front
// Accepts input items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module hmt_front (
  input  logic           clk,
  input  logic           rst_n,
  hmt_in_if.sink         in_bus,
  output logic           q_valid,
  output hmt_pkg::item_t q_item,
  input  logic           q_pop
);

  hmt_pkg::item_t buf_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  logic           pop;
  hmt_pkg::item_t item_in;

  assign in_bus.ready = (cnt_r != 2'd2);
  assign push = in_bus.valid && in_bus.ready;
  assign pop  = q_pop && (cnt_r != 2'd0);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = buf_r[rd_ptr_r];

  always_comb begin
    item_in.op          = in_bus.cmd ? hmt_pkg::OP_TICK : hmt_pkg::OP_MERGE;
    item_in.now         = in_bus.now;
    item_in.member_id   = in_bus.member_id;
    item_in.member_port = in_bus.member_port;
    item_in.member_beat = in_bus.member_beat;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// File: hw/rtl/hmt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmt_back
// Table sequencer: scans the slot memory for merges, sweeps and emits on ticks.
// ----------------------------------------------------------------------------
module hmt_back #(
  parameter int DEPTH = hmt_pkg::TABLE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hmt_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  hmt_pkg::item_t q_item,
  output logic           q_pop,
  output logic           res_valid,
  output hmt_pkg::res_t  res_data,
  input  logic           res_ready
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = $clog2(hmt_pkg::MAX_RESULTS + 1);
  localparam int OW = hmt_pkg::OCC_W;

  hmt_pkg::entry_t mem [0:DEPTH-1];
  hmt_pkg::entry_t rdata_r;

  hmt_pkg::state_t state_r, state_nxt;
  hmt_pkg::item_t  cur_r, cur_nxt;
  logic [CW-1:0]   addr_r, addr_nxt;
  logic            b_valid_r, b_valid_nxt;
  logic [IW-1:0]   b_idx_r, b_idx_nxt;
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [OW-1:0]   count_r, count_nxt;
  logic [31:0]     own_beat_r, own_beat_nxt;
  logic            free_found_r, free_found_nxt;
  logic [IW-1:0]   free_idx_r, free_idx_nxt;
  logic            hold_valid_r, hold_valid_nxt;
  hmt_pkg::entry_t hold_r, hold_nxt;
  logic [NW-1:0]   emit_n_r, emit_n_nxt;
  logic            out_valid_r, out_valid_nxt;
  hmt_pkg::res_t   out_r, out_nxt;

  logic            rd_en;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  hmt_pkg::entry_t mem_wdata;
  logic            push;
  hmt_pkg::res_t   push_data;

  logic [IW-1:0]   idx_a;
  logic            scan_left;
  logic            scan_done;
  logic            v_b;
  logic [31:0]     age;
  logic [32:0]     limit;
  logic            m_match;
  logic            greater;
  logic            t_active;
  logic            out_free;
  logic            stall;
  logic            advance;
  logic            scanning;

  assign idx_a     = addr_r[IW-1:0];
  assign scan_left = (addr_r < CW'(DEPTH));
  assign scan_done = !scan_left && !b_valid_r;
  assign v_b       = valid_r[b_idx_r];
  assign age       = cur_r.now - rdata_r.stamp;
  assign limit     = {17'd0, cfg.fail_timeout} + {17'd0, cfg.remove_timeout};
  assign m_match   = b_valid_r && v_b && (rdata_r.id == cur_r.member_id)
                     && (rdata_r.port == cur_r.member_port);
  assign greater   = cur_r.member_beat > rdata_r.beat;
  assign t_active  = b_valid_r && v_b && (age <= {16'd0, cfg.fail_timeout})
                     && (emit_n_r < NW'(hmt_pkg::MAX_RESULTS));
  assign out_free  = !out_valid_r || res_ready;
  assign stall     = ((state_r == hmt_pkg::S_MSCAN) && m_match && !out_free)
                  || ((state_r == hmt_pkg::S_TEMIT) && t_active && hold_valid_r && !out_free);
  assign advance   = !stall;
  assign scanning  = (state_r == hmt_pkg::S_MSCAN) || (state_r == hmt_pkg::S_TSWEEP)
                  || (state_r == hmt_pkg::S_TEMIT);
  assign q_pop     = (state_r == hmt_pkg::S_IDLE) && q_valid;

  assign res_valid = out_valid_r;
  assign res_data  = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hmt_pkg::S_IDLE: begin
        if (q_valid) begin
          if (q_item.op == hmt_pkg::OP_MERGE) begin
            state_nxt = hmt_pkg::S_MSCAN;
          end else if (count_r == '0) begin
            state_nxt = hmt_pkg::S_TEMPTY;
          end else begin
            state_nxt = hmt_pkg::S_TSWEEP;
          end
        end
      end
      hmt_pkg::S_MSCAN: begin
        if (m_match && out_free) begin
          state_nxt = hmt_pkg::S_IDLE;
        end else if (scan_done) begin
          state_nxt = hmt_pkg::S_MDONE;
        end
      end
      hmt_pkg::S_TSWEEP: begin
        if (scan_done) state_nxt = hmt_pkg::S_TEMIT;
      end
      hmt_pkg::S_TEMIT: begin
        if (scan_done) state_nxt = hmt_pkg::S_TEND;
      end
      hmt_pkg::S_MDONE, hmt_pkg::S_TEND, hmt_pkg::S_TEMPTY: begin
        if (out_free) state_nxt = hmt_pkg::S_IDLE;
      end
      default: state_nxt = hmt_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cur_nxt        = cur_r;
    addr_nxt       = addr_r;
    b_valid_nxt    = b_valid_r;
    b_idx_nxt      = b_idx_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    own_beat_nxt   = own_beat_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    emit_n_nxt     = emit_n_r;
    rd_en          = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = b_idx_r;
    mem_wdata      = rdata_r;
    push           = 1'b0;
    push_data      = '0;

    // read stage shared by every scan
    if (scanning && advance) begin
      if (scan_left) begin
        rd_en       = 1'b1;
        b_valid_nxt = 1'b1;
        b_idx_nxt   = idx_a;
        addr_nxt    = addr_r + 1'b1;
      end else begin
        b_valid_nxt = 1'b0;
      end
    end

    unique case (state_r)
      hmt_pkg::S_IDLE: begin
        if (q_valid) begin
          cur_nxt        = q_item;
          addr_nxt       = '0;
          b_valid_nxt    = 1'b0;
          free_found_nxt = 1'b0;
          if (q_item.op == hmt_pkg::OP_TICK && count_r != '0) begin
            own_beat_nxt = own_beat_r + 32'd1;
          end
        end
      end
      hmt_pkg::S_MSCAN: begin
        if (b_valid_r && advance) begin
          if (m_match) begin
            push                = 1'b1;
            push_data.status    = greater ? hmt_pkg::STAT_UPDATED : hmt_pkg::STAT_UNCHANGED;
            push_data.id        = cur_r.member_id;
            push_data.port      = cur_r.member_port;
            push_data.beat      = greater ? cur_r.member_beat : rdata_r.beat;
            push_data.last      = 1'b1;
            push_data.occupancy = count_r;
            b_valid_nxt         = 1'b0;
            if (greater) begin
              mem_we          = 1'b1;
              mem_wdata.beat  = cur_r.member_beat;
              mem_wdata.stamp = cur_r.now;
            end
          end else if (!v_b && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = b_idx_r;
          end
        end
      end
      hmt_pkg::S_MDONE: begin
        if (out_free) begin
          push           = 1'b1;
          push_data.id   = cur_r.member_id;
          push_data.port = cur_r.member_port;
          push_data.beat = cur_r.member_beat;
          push_data.last = 1'b1;
          if (free_found_r) begin
            mem_we                 = 1'b1;
            mem_waddr              = free_idx_r;
            mem_wdata.id           = cur_r.member_id;
            mem_wdata.port         = cur_r.member_port;
            mem_wdata.beat         = cur_r.member_beat;
            mem_wdata.stamp        = cur_r.now;
            valid_nxt[free_idx_r]  = 1'b1;
            count_nxt              = count_r + 1'b1;
            push_data.status       = hmt_pkg::STAT_INSERTED;
            push_data.occupancy    = count_r + 1'b1;
          end else begin
            push_data.status    = hmt_pkg::STAT_FULL;
            push_data.occupancy = count_r;
          end
        end
      end
      hmt_pkg::S_TSWEEP: begin
        // removal first, then own entry refresh on what survives
        if (b_valid_r && v_b) begin
          if ({1'b0, age} > limit) begin
            valid_nxt[b_idx_r] = 1'b0;
            count_nxt          = count_r - 1'b1;
          end else if (rdata_r.id == cfg.self_id) begin
            mem_we          = 1'b1;
            mem_wdata.beat  = own_beat_r;
            mem_wdata.stamp = cur_r.now;
          end
        end
        if (scan_done) begin
          addr_nxt       = '0;
          hold_valid_nxt = 1'b0;
          emit_n_nxt     = '0;
        end
      end
      hmt_pkg::S_TEMIT: begin
        // one entry held back so the final one can carry last
        if (advance && t_active) begin
          if (hold_valid_r) begin
            push                = 1'b1;
            push_data.status    = hmt_pkg::STAT_GOSSIP;
            push_data.id        = hold_r.id;
            push_data.port      = hold_r.port;
            push_data.beat      = hold_r.beat;
            push_data.last      = 1'b0;
            push_data.occupancy = count_r;
          end
          hold_nxt       = rdata_r;
          hold_valid_nxt = 1'b1;
          emit_n_nxt     = emit_n_r + 1'b1;
        end
      end
      hmt_pkg::S_TEND: begin
        if (out_free) begin
          push                = 1'b1;
          push_data.last      = 1'b1;
          push_data.occupancy = count_r;
          if (hold_valid_r) begin
            push_data.status = hmt_pkg::STAT_GOSSIP;
            push_data.id     = hold_r.id;
            push_data.port   = hold_r.port;
            push_data.beat   = hold_r.beat;
          end else begin
            push_data.status = hmt_pkg::STAT_EMPTY;
          end
        end
      end
      hmt_pkg::S_TEMPTY: begin
        if (out_free) begin
          push                = 1'b1;
          push_data.status    = hmt_pkg::STAT_EMPTY;
          push_data.last      = 1'b1;
          push_data.occupancy = count_r;
        end
      end
      default: begin
      end
    endcase

    out_nxt       = push ? push_data : out_r;
    out_valid_nxt = push ? 1'b1 : (res_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hmt_pkg::S_IDLE;
      addr_r       <= '0;
      b_valid_r    <= 1'b0;
      valid_r      <= '0;
      count_r      <= '0;
      own_beat_r   <= '0;
      free_found_r <= 1'b0;
      hold_valid_r <= 1'b0;
      emit_n_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      b_valid_r    <= b_valid_nxt;
      valid_r      <= valid_nxt;
      count_r      <= count_nxt;
      own_beat_r   <= own_beat_nxt;
      free_found_r <= free_found_nxt;
      hold_valid_r <= hold_valid_nxt;
      emit_n_r     <= emit_n_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    b_idx_r    <= b_idx_nxt;
    free_idx_r <= free_idx_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
  end

  // slot memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[idx_a];
    end
  end

endmodule

// File: dv/heartbeat_membership_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_membership_table_core_tb
// Self-checking bench for the membership table: merges, ticks and ageing are
// predicted in a scoreboard and every result transfer is compared per field,
// over several register settings with random idling on both channels.
// ----------------------------------------------------------------------------
module heartbeat_membership_table_core_tb;

  localparam int CYCLE_LIMIT = 2000000;

  class member_board;
    bit               held [hmt_pkg::TABLE_DEPTH];
    hmt_pkg::entry_t  slots [hmt_pkg::TABLE_DEPTH];
    logic [31:0]      own_beat;
    int               count;
    hmt_pkg::cfg_t    regs;
    hmt_pkg::res_t    awaited [$];
    int               errors;
    int               merges, ticks, fulls, checked;

    function void clear();
      foreach (held[i]) held[i] = 1'b0;
      own_beat = '0;
      count = 0;
      regs.fail_timeout = hmt_pkg::TFAIL;
      regs.remove_timeout = hmt_pkg::TREMOVE;
      regs.self_id = '0;
      awaited.delete();
      errors = 0; merges = 0; ticks = 0; fulls = 0; checked = 0;
    endfunction

    function void set_reg(hmt_pkg::cfg_idx_t idx, logic [31:0] d);
      case (idx)
        hmt_pkg::CFG_FAIL_TIMEOUT:   regs.fail_timeout = d[15:0];
        hmt_pkg::CFG_REMOVE_TIMEOUT: regs.remove_timeout = d[15:0];
        hmt_pkg::CFG_SELF_ID:        regs.self_id = d;
        default: ;
      endcase
    endfunction

    function hmt_pkg::res_t mk(logic [2:0] st, logic [31:0] id, logic [15:0] port,
                               logic [31:0] beat, logic lst);
      hmt_pkg::res_t r;
      r.status = st; r.id = id; r.port = port; r.beat = beat; r.last = lst;
      r.occupancy = count[hmt_pkg::OCC_W-1:0];
      return r;
    endfunction

    // append to the tail of the awaited results
    function void add_awaited(hmt_pkg::res_t r);
      awaited.insert(awaited.size(), r);
    endfunction

    // one accepted input transfer
    function void note(hmt_pkg::item_t it);
      int free_slot;
      logic [31:0] age;
      logic [32:0] limit;
      hmt_pkg::res_t run [$];
      if (it.op == hmt_pkg::OP_MERGE) begin
        merges++;
        free_slot = -1;
        for (int i = 0; i < hmt_pkg::TABLE_DEPTH; i++) begin
          if (held[i] && slots[i].id == it.member_id && slots[i].port == it.member_port) begin
            logic [2:0] st;
            st = hmt_pkg::STAT_UNCHANGED;
            if (it.member_beat > slots[i].beat) begin
              slots[i].beat = it.member_beat;
              slots[i].stamp = it.now;
              st = hmt_pkg::STAT_UPDATED;
            end
            add_awaited(mk(st, it.member_id, it.member_port, slots[i].beat, 1'b1));
            return;
          end
          if (!held[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot < 0) begin
          fulls++;
          add_awaited(mk(hmt_pkg::STAT_FULL, it.member_id, it.member_port,
                         it.member_beat, 1'b1));
          return;
        end
        held[free_slot] = 1'b1;
        slots[free_slot].id = it.member_id;
        slots[free_slot].port = it.member_port;
        slots[free_slot].beat = it.member_beat;
        slots[free_slot].stamp = it.now;
        count++;
        add_awaited(mk(hmt_pkg::STAT_INSERTED, it.member_id, it.member_port,
                       it.member_beat, 1'b1));
        return;
      end
      ticks++;
      if (count == 0) begin
        add_awaited(mk(hmt_pkg::STAT_EMPTY, '0, '0, '0, 1'b1));
        return;
      end
      limit = {17'b0, regs.fail_timeout} + {17'b0, regs.remove_timeout};
      for (int i = 0; i < hmt_pkg::TABLE_DEPTH; i++) begin
        age = it.now - slots[i].stamp;
        if (held[i] && {1'b0, age} > limit) begin
          held[i] = 1'b0;
          count--;
        end
      end
      own_beat = own_beat + 1;
      for (int i = 0; i < hmt_pkg::TABLE_DEPTH; i++)
        if (held[i] && slots[i].id == regs.self_id) begin
          slots[i].beat = own_beat;
          slots[i].stamp = it.now;
        end
      for (int i = 0; i < hmt_pkg::TABLE_DEPTH && run.size() < hmt_pkg::MAX_RESULTS; i++) begin
        age = it.now - slots[i].stamp;
        if (held[i] && age <= {16'b0, regs.fail_timeout})
          run.insert(run.size(), mk(hmt_pkg::STAT_GOSSIP, slots[i].id, slots[i].port,
                                    slots[i].beat, 1'b0));
      end
      if (run.size() == 0) begin
        add_awaited(mk(hmt_pkg::STAT_EMPTY, '0, '0, '0, 1'b1));
        return;
      end
      run[run.size()-1].last = 1'b1;
      foreach (run[k]) add_awaited(run[k]);
    endfunction

    // one result transfer
    function void check(hmt_pkg::res_t got);
      hmt_pkg::res_t want;
      checked++;
      if (awaited.size() == 0) begin
        $error("result: expected none, got status %0d id %h", got.status, got.id);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status); errors++;
      end
      if (got.id !== want.id) begin
        $error("out_id: expected %h, actual %h", want.id, got.id); errors++;
      end
      if (got.port !== want.port) begin
        $error("out_port: expected %h, actual %h", want.port, got.port); errors++;
      end
      if (got.beat !== want.beat) begin
        $error("out_beat: expected %h, actual %h", want.beat, got.beat); errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last); errors++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  hmt_in_if  in_bus ();
  hmt_out_if out_bus ();
  hmt_cfg_if cfg_bus ();

  heartbeat_membership_table_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  member_board board;
  bit          no_idle;
  int          cycles;
  logic [31:0] clock_now;
  logic [31:0] id_pool [8];

  initial begin
    board = new();
    board.clear();
    in_bus.valid <= 1'b0;
    in_bus.cmd <= hmt_pkg::OP_MERGE;
    in_bus.now <= '0;
    in_bus.member_id <= '0;
    in_bus.member_port <= '0;
    in_bus.member_beat <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= hmt_pkg::CFG_FAIL_TIMEOUT;
    cfg_bus.data <= '0;
    out_bus.ready <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** heartbeat_membership_table_core: FAILED **");
      $finish;
    end
  end
  initial cycles = 0;

  // result side back-pressure
  initial begin
    int n;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    hmt_pkg::res_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.status = out_bus.status;
      got.id = out_bus.out_id;
      got.port = out_bus.out_port;
      got.beat = out_bus.out_beat;
      got.last = out_bus.last;
      got.occupancy = out_bus.occupancy;
      board.check(got);
    end
  end

  task automatic send(hmt_pkg::op_t op, logic [31:0] now, logic [31:0] id,
                      logic [15:0] port, logic [31:0] beat);
    hmt_pkg::item_t it;
    int gap;
    it.op = op; it.now = now; it.member_id = id; it.member_port = port; it.member_beat = beat;
    in_bus.valid <= 1'b1;
    in_bus.cmd <= op;
    in_bus.now <= now;
    in_bus.member_id <= id;
    in_bus.member_port <= port;
    in_bus.member_beat <= beat;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    board.note(it);
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // leaves valid high so writes can follow back to back; the caller drops it
  task automatic write_reg(hmt_pkg::cfg_idx_t idx, logic [31:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= d;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    board.set_reg(idx, d);
  endtask

  task automatic random_item();
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] beat;
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) clock_now = $urandom();
    else if (r < 3) clock_now += $urandom_range(0, 60);
    else clock_now += $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) begin
      send(hmt_pkg::OP_TICK, clock_now, $urandom(), 16'($urandom()), $urandom());
      return;
    end
    id = ($urandom_range(0, 7) == 0) ? $urandom() : id_pool[$urandom_range(0, 7)];
    case ($urandom_range(0, 3))
      0: port = 16'hFFFF;
      1: port = 16'($urandom());
      default: port = 16'($urandom_range(0, 1));
    endcase
    beat = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 40);
    send(hmt_pkg::OP_MERGE, clock_now, id, port, beat);
  endtask

  initial begin
    int n_phase;
    no_idle = 1'b0;
    clock_now = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, self id zero
    send(hmt_pkg::OP_TICK, 32'd0, '0, '0, '0);                      // empty table
    send(hmt_pkg::OP_MERGE, 32'd0, 32'd0, 16'd0, 32'd0);            // own entry inserted
    send(hmt_pkg::OP_MERGE, 32'd1, 32'd0, 16'd0, 32'd0);            // same beat, unchanged
    send(hmt_pkg::OP_MERGE, 32'd1, 32'd0, 16'd0, 32'hFFFF_FFFF);    // grows
    send(hmt_pkg::OP_MERGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd5);
    send(hmt_pkg::OP_MERGE, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 32'd9); // own id, other port
    send(hmt_pkg::OP_TICK, 32'hFFFF_FFFF, '0, '0, '0);
    send(hmt_pkg::OP_TICK, 32'd3, '0, '0, '0);                      // time wraps
    send(hmt_pkg::OP_TICK, 32'd100, '0, '0, '0);                    // everything stale
    send(hmt_pkg::OP_MERGE, 32'd100, 32'd7, 16'd1, 32'd1);
    send(hmt_pkg::OP_TICK, 32'd110, '0, '0, '0);                    // held but not active
    send(hmt_pkg::OP_TICK, 32'd125, '0, '0, '0);                    // exactly at removal bound
    send(hmt_pkg::OP_TICK, 32'd126, '0, '0, '0);
    // fill the table, then overflow it
    for (int i = 0; i < hmt_pkg::TABLE_DEPTH; i++)
      send(hmt_pkg::OP_MERGE, 32'd200, 32'h1000 + i, i[15:0], i);
    send(hmt_pkg::OP_MERGE, 32'd200, 32'hDEAD_BEEF, 16'h5555, 32'hAAAA_AAAA);
    send(hmt_pkg::OP_TICK, 32'd205, '0, '0, '0);                    // full emission run
    send(hmt_pkg::OP_TICK, 32'd206, '0, '0, '0);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_reg(hmt_pkg::CFG_FAIL_TIMEOUT, 32'd0);
          write_reg(hmt_pkg::CFG_REMOVE_TIMEOUT, 32'd0);
          write_reg(hmt_pkg::CFG_SELF_ID, 32'h0000_0003);
        end
        1: begin
          write_reg(hmt_pkg::CFG_FAIL_TIMEOUT, 32'd65535);
          write_reg(hmt_pkg::CFG_REMOVE_TIMEOUT, 32'd65535);
          write_reg(hmt_pkg::CFG_SELF_ID, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(hmt_pkg::CFG_FAIL_TIMEOUT, $urandom_range(0, 65535));
          write_reg(hmt_pkg::CFG_REMOVE_TIMEOUT, $urandom_range(0, 65535));
          write_reg(hmt_pkg::CFG_SELF_ID, $urandom());
        end
        3: begin
          write_reg(hmt_pkg::CFG_FAIL_TIMEOUT, 32'd3);
          write_reg(hmt_pkg::CFG_REMOVE_TIMEOUT, 32'd2);
          write_reg(hmt_pkg::CFG_SELF_ID, 32'h0000_0005);
        end
        default: begin
          write_reg(hmt_pkg::CFG_FAIL_TIMEOUT, 32'd5);
          write_reg(hmt_pkg::CFG_REMOVE_TIMEOUT, 32'd20);
          write_reg(hmt_pkg::CFG_SELF_ID, 32'd0);
        end
      endcase
      cfg_bus.valid <= 1'b0;
      // small id pool keeps hits and updates frequent; own id is in it
      foreach (id_pool[k]) id_pool[k] = (k < 5) ? k : $urandom();
      id_pool[7] = board.regs.self_id;
      no_idle = (p == 3);
      n_phase = 60 + $urandom_range(0, 10);
      for (int k = 0; k < n_phase; k++) begin
        if (k == n_phase / 2) begin
          no_idle = ~no_idle;
          drain();
        end
        random_item();
      end
      drain();
    end

    $display("covered %0d merges (%0d on a full table) and %0d ticks, %0d results checked",
             board.merges, board.fulls, board.ticks, board.checked);
    if (board.errors == 0) begin
      $display("** heartbeat_membership_table_core: PASSED **");
    end else begin
      $display("** heartbeat_membership_table_core: FAILED **");
    end
    $finish;
  end

endmodule
